// ===== src/tmsb_pkg.sv =====
// ----------------------------------------------------------------------------
// Text-mode screen buffer package
// Operation codes, register indexes, the stored cell word and its blank value.
// ----------------------------------------------------------------------------
package tmsb_pkg;

    typedef enum logic [2:0] {
        OP_PUT_BYTE   = 3'd0,
        OP_SET_CURSOR = 3'd1,
        OP_NEW_LINE   = 3'd2,
        OP_CLEAR      = 3'd3,
        OP_FRAME_TICK = 3'd4,
        OP_READ_CELL  = 3'd5
    } op_t;

    typedef enum logic {
        CFG_BLINK_HALF_PERIOD = 1'b0,
        CFG_CURSOR_ENABLE     = 1'b1
    } cfg_index_t;

    localparam logic [1:0] ATTR_NORMAL   = 2'd0;
    localparam logic [1:0] ATTR_INVERTED = 2'd1;
    localparam logic [1:0] ATTR_BLINKING = 2'd2;

    localparam logic [7:0] LEAD_BYTE = 8'hC3;

    typedef struct packed {
        logic [1:0]  attr;
        logic [7:0]  cont;
        logic [7:0]  first;
        logic [23:0] fg;
        logic [23:0] bg;
    } cell_t;

    localparam cell_t BLANK_CELL = '{
        attr:  ATTR_NORMAL,
        cont:  8'h00,
        first: 8'h20,
        fg:    24'hFFFFFF,
        bg:    24'h0000FF
    };

endpackage

// ===== src/text_mode_screen_buffer.sv =====
// ----------------------------------------------------------------------------
// Text-mode screen buffer
// Character cell store with cursor, UTF-8 lead byte, scrolling and blink.
// ----------------------------------------------------------------------------
// The block keeps LINES x COLUMNS cells in one synchronous memory, with rows
// held as a ring addressed through a top-row pointer, so a scroll moves the
// pointer and blanks one row instead of copying the screen. Items are handled
// one at a time. A read_cell goes through the memory read and the registered
// result; set_cursor, new_line, frame_tick and unused codes go through the
// done state, a scrolling set_cursor after its sweep. A put_byte goes through
// the accept, the cell write and the registered result. Every scroll runs a
// blanking sweep that writes one cell a cycle through the single write port;
// a put_byte can meet two scrolls (a pending one before the write and a wrap
// after it). A clear sweeps all LINES x COLUMNS cells the same way. After
// reset the block runs a clearing pass over all LINES x COLUMNS cells before
// it takes its first item; configuration writes are taken at any time.
module text_mode_screen_buffer #(
    parameter int LINES   = 30,
    parameter int COLUMNS = 80
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  op,
    input  logic [7:0]  char_byte,
    input  logic [4:0]  line,
    input  logic [6:0]  column,
    input  logic [23:0] fg_color,
    input  logic [23:0] bg_color,
    input  logic [1:0]  attribute,

    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] shown_char,
    output logic [23:0] glyph_color,
    output logic [23:0] back_color,
    output logic        glyph_visible,
    output logic        cursor_here,
    output logic [4:0]  cursor_line,
    output logic [6:0]  cursor_column,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data
);

    localparam int DEPTH  = LINES * COLUMNS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int TOP_W  = $clog2(LINES);
    localparam int ROW_W  = $clog2(LINES + 1);
    localparam int COL_W  = $clog2(COLUMNS + 1);

    localparam logic [7:0]        LINES8 = 8'(LINES);
    localparam logic [7:0]        COLS8  = 8'(COLUMNS);
    localparam logic [ADDR_W-1:0] COLS_A = ADDR_W'(COLUMNS);
    localparam logic [ADDR_W-1:0] LAST_A = ADDR_W'(DEPTH - 1);
    localparam logic [ADDR_W-1:0] ROWN_A = ADDR_W'(COLUMNS - 1);

    typedef enum logic [2:0] {
        S_SWEEP,
        S_IDLE,
        S_READ,
        S_PUT,
        S_DONE
    } state_t;

    state_t                 state_reg;
    state_t                 ret_reg;

    logic [TOP_W-1:0]       top_reg;
    logic [ROW_W-1:0]       crow_reg;
    logic [COL_W-1:0]       ccol_reg;
    logic [7:0]             blink_count_reg;
    logic                   blink_phase_reg;
    logic                   pending_reg;
    logic [7:0]             half_period_reg;
    logic                   cursor_en_reg;

    logic [ADDR_W-1:0]      sweep_addr_reg;
    logic [ADDR_W-1:0]      sweep_left_reg;

    // Item fields kept for a put_byte, and the lead cell while it waits.
    logic [7:0]             byte_reg;
    tmsb_pkg::cell_t        item_cell_reg;
    tmsb_pkg::cell_t        pend_cell_reg;

    logic                   in_range_reg;
    logic                   here_reg;

    logic                   out_valid_reg;
    logic [15:0]            shown_reg;
    logic [23:0]            glyph_reg;
    logic [23:0]            back_reg;
    logic                   vis_reg;
    logic                   here_out_reg;

    // Memory ports.
    logic                   mem_we;
    logic [ADDR_W-1:0]      mem_waddr;
    tmsb_pkg::cell_t        mem_wdata;
    logic [ADDR_W-1:0]      mem_raddr;
    tmsb_pkg::cell_t        mem_rdata;

    tmsb_cell_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Physical address of a logical row and column: the ring offset is below
    // twice LINES, so one compare and subtract brings it back into range.
    function automatic logic [ADDR_W-1:0] cell_addr(
        input logic [TOP_W-1:0] top,
        input logic [TOP_W-1:0] row,
        input logic [COL_W-1:0] col
    );
        logic [TOP_W:0]   sum;
        logic [TOP_W-1:0] phys;
        sum  = {1'b0, top} + {1'b0, row};
        if (sum >= (TOP_W + 1)'(LINES))
        begin
            sum = sum - (TOP_W + 1)'(LINES);
        end
        phys = sum[TOP_W-1:0];
        return ADDR_W'(phys) * COLS_A + ADDR_W'(col);
    endfunction

    logic [7:0] line8;
    logic [7:0] col8;
    logic [7:0] crow8;
    logic [7:0] ccol8;
    logic       in_fire;
    logic       read_in_range;

    assign line8         = {3'b000, line};
    assign col8          = {1'b0, column};
    assign crow8         = 8'(crow_reg);
    assign ccol8         = 8'(ccol_reg);
    assign in_ready      = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign in_fire       = in_valid && in_ready;
    assign read_in_range = (line8 < LINES8) && (col8 < COLS8);
    assign cfg_ready     = 1'b1;

    // Reads always follow the input fields; only a read_cell uses the data.
    assign mem_raddr = cell_addr(top_reg, TOP_W'(line), COL_W'(column));

    // Cell written by a put_byte in the PUT state.
    tmsb_pkg::cell_t put_cell;
    always_comb
    begin
        if (pending_reg)
        begin
            put_cell      = pend_cell_reg;
            put_cell.cont = byte_reg;
        end
        else
        begin
            put_cell = item_cell_reg;
        end
    end

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = sweep_addr_reg;
        mem_wdata = tmsb_pkg::BLANK_CELL;
        if (state_reg == S_SWEEP)
        begin
            mem_we = 1'b1;
        end
        else if (state_reg == S_PUT)
        begin
            mem_we    = 1'b1;
            mem_waddr = cell_addr(top_reg, TOP_W'(crow_reg), ccol_reg);
            mem_wdata = put_cell;
        end
    end

    // set_cursor target after saturation and wrap.
    logic [7:0] sc_row;
    logic [7:0] sc_col;
    logic       sc_scroll;
    always_comb
    begin
        sc_row    = (line8 > LINES8) ? LINES8 : line8;
        sc_col    = (col8 > COLS8) ? COLS8 : col8;
        sc_scroll = 1'b0;
        if (sc_col == COLS8)
        begin
            sc_col = 8'd0;
            if (sc_row + 8'd1 == LINES8)
            begin
                sc_scroll = 1'b1;
            end
            else if (sc_row < LINES8)
            begin
                sc_row = sc_row + 8'd1;
            end
        end
    end

    logic [TOP_W-1:0] top_inc;
    assign top_inc = (top_reg == TOP_W'(LINES - 1)) ? '0 : top_reg + TOP_W'(1);

    logic [8:0] blink_inc;
    assign blink_inc = {1'b0, blink_count_reg} + 9'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_SWEEP;
            ret_reg         <= S_IDLE;
            top_reg         <= '0;
            crow_reg        <= '0;
            ccol_reg        <= '0;
            blink_count_reg <= '0;
            blink_phase_reg <= 1'b1;
            pending_reg     <= 1'b0;
            half_period_reg <= 8'd30;
            cursor_en_reg   <= 1'b1;
            sweep_addr_reg  <= '0;
            sweep_left_reg  <= LAST_A;
            out_valid_reg   <= 1'b0;
            byte_reg        <= '0;
            item_cell_reg   <= tmsb_pkg::BLANK_CELL;
            pend_cell_reg   <= tmsb_pkg::BLANK_CELL;
            in_range_reg    <= 1'b0;
            here_reg        <= 1'b0;
            shown_reg       <= '0;
            glyph_reg       <= '0;
            back_reg        <= '0;
            vis_reg         <= 1'b0;
            here_out_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    tmsb_pkg::CFG_BLINK_HALF_PERIOD: half_period_reg <= cfg_data;
                    tmsb_pkg::CFG_CURSOR_ENABLE:     cursor_en_reg   <= cfg_data[0];
                    default: ;
                endcase
            end

            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_SWEEP:
                begin
                    if (sweep_left_reg == '0)
                    begin
                        state_reg <= ret_reg;
                    end
                    else
                    begin
                        sweep_addr_reg <= sweep_addr_reg + ADDR_W'(1);
                        sweep_left_reg <= sweep_left_reg - ADDR_W'(1);
                    end
                end

                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        byte_reg           <= char_byte;
                        item_cell_reg.attr  <= attribute;
                        item_cell_reg.cont  <= 8'h00;
                        item_cell_reg.first <= char_byte;
                        item_cell_reg.fg    <= fg_color;
                        item_cell_reg.bg    <= bg_color;
                        in_range_reg       <= read_in_range;
                        here_reg           <= cursor_en_reg && blink_phase_reg
                                              && (crow8 == line8) && (ccol8 == col8);
                        case (op)
                            tmsb_pkg::OP_PUT_BYTE:
                            begin
                                if (crow_reg == ROW_W'(LINES))
                                begin
                                    // A scroll left pending when new_line or set_cursor moved past the last row.
                                    crow_reg       <= ROW_W'(LINES - 1);
                                    top_reg        <= top_inc;
                                    sweep_addr_reg <= ADDR_W'(top_reg) * COLS_A;
                                    sweep_left_reg <= ROWN_A;
                                    ret_reg        <= S_PUT;
                                    state_reg      <= S_SWEEP;
                                end
                                else
                                begin
                                    state_reg <= S_PUT;
                                end
                            end
                            tmsb_pkg::OP_SET_CURSOR:
                            begin
                                pending_reg <= 1'b0;
                                crow_reg    <= ROW_W'(sc_row);
                                ccol_reg    <= COL_W'(sc_col);
                                if (sc_scroll)
                                begin
                                    top_reg        <= top_inc;
                                    sweep_addr_reg <= ADDR_W'(top_reg) * COLS_A;
                                    sweep_left_reg <= ROWN_A;
                                    ret_reg        <= S_DONE;
                                    state_reg      <= S_SWEEP;
                                end
                                else
                                begin
                                    state_reg <= S_DONE;
                                end
                            end
                            tmsb_pkg::OP_NEW_LINE:
                            begin
                                pending_reg <= 1'b0;
                                ccol_reg    <= '0;
                                if (crow8 < LINES8)
                                begin
                                    crow_reg <= crow_reg + ROW_W'(1);
                                end
                                state_reg <= S_DONE;
                            end
                            tmsb_pkg::OP_CLEAR:
                            begin
                                pending_reg    <= 1'b0;
                                crow_reg       <= '0;
                                ccol_reg       <= '0;
                                top_reg        <= '0;
                                sweep_addr_reg <= '0;
                                sweep_left_reg <= LAST_A;
                                ret_reg        <= S_DONE;
                                state_reg      <= S_SWEEP;
                            end
                            tmsb_pkg::OP_FRAME_TICK:
                            begin
                                if (blink_inc > {1'b0, half_period_reg})
                                begin
                                    blink_count_reg <= '0;
                                    blink_phase_reg <= !blink_phase_reg;
                                end
                                else
                                begin
                                    blink_count_reg <= blink_inc[7:0];
                                end
                                state_reg <= S_DONE;
                            end
                            tmsb_pkg::OP_READ_CELL:
                            begin
                                state_reg <= S_READ;
                            end
                            default:
                            begin
                                state_reg <= S_DONE;
                            end
                        endcase
                    end
                end

                S_READ:
                begin
                    out_valid_reg <= 1'b1;
                    if (in_range_reg)
                    begin
                        shown_reg    <= {mem_rdata.cont, mem_rdata.first};
                        here_out_reg <= here_reg;
                        if (mem_rdata.attr == tmsb_pkg::ATTR_INVERTED)
                        begin
                            glyph_reg <= mem_rdata.bg;
                            back_reg  <= mem_rdata.fg;
                            vis_reg   <= 1'b1;
                        end
                        else
                        begin
                            glyph_reg <= mem_rdata.fg;
                            back_reg  <= mem_rdata.bg;
                            vis_reg   <= (mem_rdata.attr == tmsb_pkg::ATTR_BLINKING)
                                         ? blink_phase_reg : 1'b1;
                        end
                    end
                    else
                    begin
                        shown_reg    <= '0;
                        glyph_reg    <= '0;
                        back_reg     <= '0;
                        vis_reg      <= 1'b0;
                        here_out_reg <= 1'b0;
                    end
                    state_reg <= S_IDLE;
                end

                S_PUT:
                begin
                    // The cell is written this cycle; now move the cursor, unless a lead byte waits.
                    if (!pending_reg && (byte_reg == tmsb_pkg::LEAD_BYTE))
                    begin
                        pending_reg   <= 1'b1;
                        pend_cell_reg <= item_cell_reg;
                        state_reg     <= S_DONE;
                    end
                    else
                    begin
                        pending_reg <= 1'b0;
                        if (ccol8 + 8'd1 >= COLS8)
                        begin
                            ccol_reg <= '0;
                            if (crow8 + 8'd1 >= LINES8)
                            begin
                                crow_reg       <= ROW_W'(LINES - 1);
                                top_reg        <= top_inc;
                                sweep_addr_reg <= ADDR_W'(top_reg) * COLS_A;
                                sweep_left_reg <= ROWN_A;
                                ret_reg        <= S_DONE;
                                state_reg      <= S_SWEEP;
                            end
                            else
                            begin
                                crow_reg  <= crow_reg + ROW_W'(1);
                                state_reg <= S_DONE;
                            end
                        end
                        else
                        begin
                            ccol_reg  <= ccol_reg + COL_W'(1);
                            state_reg <= S_DONE;
                        end
                    end
                end

                S_DONE:
                begin
                    out_valid_reg <= 1'b1;
                    shown_reg     <= '0;
                    glyph_reg     <= '0;
                    back_reg      <= '0;
                    vis_reg       <= 1'b0;
                    here_out_reg  <= 1'b0;
                    state_reg     <= S_IDLE;
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid     = out_valid_reg;
    assign shown_char    = shown_reg;
    assign glyph_color   = glyph_reg;
    assign back_color    = back_reg;
    assign glyph_visible = vis_reg;
    assign cursor_here   = here_out_reg;
    assign cursor_line   = 5'(crow_reg);
    assign cursor_column = 7'(ccol_reg);

`ifndef NO_ASSERTIONS
    // Items are only taken when no sweep or earlier item is in progress.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |-> state_reg == S_IDLE)
        else $error("item accepted while busy");

    // A read_cell result is registered in the cycle after the memory read, which
    // happens as the item is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && op == tmsb_pkg::OP_READ_CELL |-> ##2 out_valid_reg)
        else $error("read result late");

    // The stored cursor column is always a real column.
    assert property (@(posedge clk) disable iff (!rst_n)
        ccol8 < COLS8)
        else $error("cursor column out of range");

    // A waiting lead byte sits on a real row, so no scroll can split it.
    assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg |-> crow8 < LINES8)
        else $error("lead byte pending on scroll row");
`endif

endmodule

// ===== src/tmsb_cell_store.sv =====
// ----------------------------------------------------------------------------
// Cell store
// Single-port-write, single-port-read memory of cells with registered read data.
// ----------------------------------------------------------------------------
module tmsb_cell_store #(
    parameter int DEPTH  = 2400,
    parameter int ADDR_W = 12
) (
    input  logic                clk,
    input  logic                we,
    input  logic [ADDR_W-1:0]   waddr,
    input  tmsb_pkg::cell_t     wdata,
    input  logic [ADDR_W-1:0]   raddr,
    output tmsb_pkg::cell_t     rdata
);

    tmsb_pkg::cell_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
